// ===== rtl/slht_pkg.sv =====
`default_nettype none
package slht_pkg;

  localparam int unsigned CFG_W  = 64;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned AGE_W  = 32;

  localparam logic [IDX_W-1:0] REG_ONLINE_POLL  = 2'd0;
  localparam logic [IDX_W-1:0] REG_OFFLINE_POLL = 2'd1;
  localparam logic [IDX_W-1:0] REG_MAX_AGE      = 2'd2;
  localparam logic [IDX_W-1:0] REG_EXPECTED_ID  = 2'd3;

  localparam logic [31:0] ONLINE_POLL_RST  = 32'd1000;
  localparam logic [31:0] OFFLINE_POLL_RST = 32'd5000;
  localparam logic [31:0] MAX_AGE_RST      = 32'd10000;
  localparam logic [63:0] EXPECTED_ID_RST  = 64'd0;

  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

  // internal link state codes
  localparam logic [2:0] LC_UNKNOWN = 3'd0;
  localparam logic [2:0] LC_OFFLINE = 3'd1;
  localparam logic [2:0] LC_ONLINE  = 3'd2;
  localparam logic [2:0] LC_PROTO   = 3'd3;
  localparam logic [2:0] LC_STALE   = 3'd4;

  // reported link state
  localparam logic [1:0] LS_OFFLINE = 2'd0;
  localparam logic [1:0] LS_ONLINE  = 2'd1;
  localparam logic [1:0] LS_PROTO   = 2'd2;
  localparam logic [1:0] LS_STALE   = 2'd3;

  // state events
  localparam logic [2:0] EVT_NONE    = 3'd0;
  localparam logic [2:0] EVT_ONLINE  = 3'd1;
  localparam logic [2:0] EVT_OFFLINE = 3'd2;
  localparam logic [2:0] EVT_PROTO   = 3'd3;
  localparam logic [2:0] EVT_STALE   = 3'd4;

  typedef struct packed {
    logic [1:0]       link_state;
    logic [2:0]       state_event;
    logic             new_snapshot;
    logic             poll_ok;
    logic             snapshot_valid;
    logic [AGE_W-1:0] age_ms;
    logic [31:0]      next_poll_ms;
  } result_t;

  function automatic logic [1:0] state_out(input logic [2:0] code);
    logic [1:0] s;
    case (code)
      LC_ONLINE: s = LS_ONLINE;
      LC_PROTO:  s = LS_PROTO;
      LC_STALE:  s = LS_STALE;
      default:   s = LS_OFFLINE;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] event_of(input logic [2:0] code);
    logic [2:0] e;
    case (code)
      LC_ONLINE:  e = EVT_ONLINE;
      LC_OFFLINE: e = EVT_OFFLINE;
      LC_PROTO:   e = EVT_PROTO;
      LC_STALE:   e = EVT_STALE;
      default:    e = EVT_NONE;
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sensor_link_health_tracker_unit.sv =====
// each result is registered in the result register, or in the skid entry on a stall
// one item per cycle while skid is empty; state and result logic sit in one stage
// a two-entry result buffer keeps input ready while one result waits
// reset: link state unknown, no snapshot, age 0, registers at defaults, buffer empty
// no clearing pass; boot and sequence registers are read only once a snapshot exists
`default_nettype none
module sensor_link_health_tracker_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [slht_pkg::ADDR_W-1:0] paddr,
  input  wire logic [slht_pkg::CFG_W-1:0]  pwdata,
  output logic      [slht_pkg::CFG_W-1:0]  prdata,
  output logic                             pready,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        kind,
  input  wire logic                        probe_ok,
  input  wire logic                        read_ok,
  input  wire logic                        decode_ok,
  input  wire logic [63:0]                 sensor_id,
  input  wire logic [31:0]                 boot_id,
  input  wire logic [31:0]                 sequence_req,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       link_state,
  output logic [2:0]                       state_event,
  output logic                             new_snapshot,
  output logic                             poll_ok,
  output logic                             snapshot_valid,
  output logic [31:0]                      age_ms,
  output logic [31:0]                      next_poll_ms
);
  import slht_pkg::*;

  logic [31:0] online_poll;
  logic [31:0] offline_poll;
  logic [31:0] max_age;
  logic [63:0] expected_id;

  logic [2:0]       link_code, link_code_next;
  logic             have_snapshot, have_snapshot_next;
  logic [31:0]      prior_sequence;
  logic [31:0]      prior_boot;
  logic [AGE_W-1:0] snapshot_age, snapshot_age_next;

  result_t res_next;
  result_t res;
  result_t skid;
  logic    skid_valid;
  logic    accepted;
  logic    failed;
  logic    in_xfer;
  logic    cfg_wr;
  logic [IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_W-1:ADDR_W-IDX_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      online_poll  <= ONLINE_POLL_RST;
      offline_poll <= OFFLINE_POLL_RST;
      max_age      <= MAX_AGE_RST;
      expected_id  <= EXPECTED_ID_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ONLINE_POLL:  online_poll  <= pwdata[31:0];
        REG_OFFLINE_POLL: offline_poll <= pwdata[31:0];
        REG_MAX_AGE:      max_age      <= pwdata[31:0];
        REG_EXPECTED_ID:  expected_id  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ONLINE_POLL:  prdata = {32'd0, online_poll};
      REG_OFFLINE_POLL: prdata = {32'd0, offline_poll};
      REG_MAX_AGE:      prdata = {32'd0, max_age};
      REG_EXPECTED_ID:  prdata = expected_id;
      default:          prdata = '0;
    endcase
  end

  assign in_ready = !skid_valid;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    link_code_next     = link_code;
    have_snapshot_next = have_snapshot;
    snapshot_age_next  = snapshot_age;
    accepted           = 1'b0;
    failed             = 1'b0;
    if (kind) begin
      if (have_snapshot && snapshot_age != AGE_MAX) begin
        snapshot_age_next = snapshot_age + AGE_W'(1);
      end
    end else if (!probe_ok || !read_ok) begin
      link_code_next = LC_OFFLINE;
      failed         = 1'b1;
    end else if (!decode_ok || (expected_id != 64'd0 && sensor_id != expected_id)) begin
      link_code_next = LC_PROTO;
      failed         = 1'b1;
    end else if (!have_snapshot || boot_id != prior_boot || sequence_req != prior_sequence) begin
      link_code_next     = LC_ONLINE;
      have_snapshot_next = 1'b1;
      snapshot_age_next  = '0;
      accepted           = 1'b1;
    end
    if (link_code_next != LC_UNKNOWN && have_snapshot_next && snapshot_age_next > max_age) begin
      link_code_next = LC_STALE;
    end

    res_next.link_state     = state_out(link_code_next);
    res_next.state_event    = (link_code_next != link_code) ? event_of(link_code_next)
                                                            : EVT_NONE;
    res_next.new_snapshot   = accepted;
    res_next.poll_ok        = !kind && !failed && link_code_next == LC_ONLINE;
    res_next.snapshot_valid = have_snapshot_next && snapshot_age_next <= max_age;
    res_next.age_ms         = have_snapshot_next ? snapshot_age_next : '0;
    res_next.next_poll_ms   = (link_code_next == LC_ONLINE) ? online_poll : offline_poll;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_code     <= LC_UNKNOWN;
      have_snapshot <= 1'b0;
      snapshot_age  <= '0;
    end else if (in_xfer) begin
      link_code     <= link_code_next;
      have_snapshot <= have_snapshot_next;
      snapshot_age  <= snapshot_age_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && accepted) begin
      prior_sequence <= sequence_req;
      prior_boot     <= boot_id;
    end
  end

  // result register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        res <= skid;
      end else if (in_xfer) begin
        res <= res_next;
      end
    end else if (in_xfer) begin
      skid <= res_next;
    end
  end

  assign link_state     = res.link_state;
  assign state_event    = res.state_event;
  assign new_snapshot   = res.new_snapshot;
  assign poll_ok        = res.poll_ok;
  assign snapshot_valid = res.snapshot_valid;
  assign age_ms         = res.age_ms;
  assign next_poll_ms   = res.next_poll_ms;

endmodule
`default_nettype wire

// ===== rtl/slht_checker.sv =====
`default_nettype none
module slht_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  link_state,
  input wire logic [2:0]  state_event,
  input wire logic        new_snapshot,
  input wire logic        poll_ok,
  input wire logic [31:0] age_ms
);
  import slht_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(link_state) && $stable(age_ms))
    else $error("stalled result changed");

  a_snapshot_online: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_snapshot |-> age_ms == 32'd0 && link_state == LS_ONLINE && poll_ok)
    else $error("new snapshot without fresh online state");

  a_event_online: assert property (@(posedge clk) disable iff (rst)
    out_valid && state_event == EVT_ONLINE |-> link_state == LS_ONLINE)
    else $error("online event with other state");

  a_poll_ok_online: assert property (@(posedge clk) disable iff (rst)
    out_valid && poll_ok |-> link_state == LS_ONLINE)
    else $error("poll ok while not online");

endmodule

bind sensor_link_health_tracker_unit slht_checker u_slht_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .link_state   (link_state),
  .state_event  (state_event),
  .new_snapshot (new_snapshot),
  .poll_ok      (poll_ok),
  .age_ms       (age_ms)
);
`default_nettype wire
